>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and controller/datapath interface types for the LRU cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } lkvc_cmd_t;

    typedef struct packed {
        logic scan_last;
    } lkvc_status_t;

endpackage

>>> rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: accept a request, step the entry scan, commit and post result.
// ----------------------------------------------------------------------------
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lkvc_status_t status,
    output lkvc_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load   = in_valid && (state_reg == S_IDLE);
        cmd.scan   = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_COMMIT) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry store, recency ranks, one-entry-per-cycle key scan, result register.
// ----------------------------------------------------------------------------
module lkvc_datapath
    import lkvc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lkvc_cmd_t               cmd,
    output lkvc_status_t            status,
    input  logic                    command,
    input  logic signed [KEY_W-1:0] lookup_key,
    input  logic signed [VAL_W-1:0] write_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        capacity,
    output logic                    hit,
    output logic signed [VAL_W-1:0] read_value
);

    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [VAL_W-1:0]  val_mem [DEPTH];
    logic [RANK_W-1:0] rank_reg [DEPTH];
    logic [RANK_W-1:0] rank_next [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CAP_W-1:0]  capacity_reg;

    logic              req_cmd_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [VAL_W-1:0]  req_val_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              hit_reg;
    logic [VAL_W-1:0]  read_value_reg;

    logic [31:0]       cap_wide;
    logic [CNT_W-1:0]  cap_eff;
    logic              evicting;
    logic [RANK_W-1:0] evict_rank;
    logic              scan_hit;
    logic              scan_free;
    logic [RANK_W-1:0] match_rank;

    assign cfg_ready        = 1'b1;
    assign status.scan_last = (scan_idx_reg == IDX_W'(DEPTH - 1));
    assign hit              = hit_reg;
    assign read_value       = read_value_reg;

    always_comb
    begin
        cap_wide = 32'(capacity_reg);
        if (cap_wide == 32'd0)
            cap_eff = CNT_W'(1);
        else if (cap_wide > 32'(DEPTH))
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = CNT_W'(capacity_reg);
    end

    assign evicting   = (count_reg >= cap_eff);
    assign evict_rank = RANK_W'(cap_eff - CNT_W'(1));
    assign scan_hit   = valid_reg[scan_idx_reg] && (key_mem[scan_idx_reg] == req_key_reg);
    assign scan_free  = !valid_reg[scan_idx_reg]
                        || (evicting && (rank_reg[scan_idx_reg] >= evict_rank));
    assign match_rank = rank_reg[match_idx_reg];

    // rank/valid update on commit: touch on hit, evict+insert on put miss
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < DEPTH; j++)
            rank_next[j] = rank_reg[j];
        if (cmd.commit)
        begin
            if (match_found_reg)
            begin
                for (int j = 0; j < DEPTH; j++)
                    if (valid_reg[j] && (rank_reg[j] < match_rank))
                        rank_next[j] = rank_reg[j] + RANK_W'(1);
                rank_next[match_idx_reg] = '0;
            end
            else if ((req_cmd_reg == CMD_PUT) && free_found_reg)
            begin
                for (int j = 0; j < DEPTH; j++)
                begin
                    if (valid_reg[j])
                    begin
                        if (evicting && (rank_reg[j] >= evict_rank))
                            valid_next[j] = 1'b0;
                        else
                            rank_next[j] = rank_reg[j] + RANK_W'(1);
                    end
                end
                valid_next[free_idx_reg] = 1'b1;
                rank_next[free_idx_reg]  = '0;
                count_next = evicting ? cap_eff : count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            count_reg       <= '0;
            capacity_reg    <= CAP_RESET;
            scan_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                capacity_reg <= capacity;
            if (cmd.load)
            begin
                scan_idx_reg    <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (scan_hit && !match_found_reg)
                    match_found_reg <= 1'b1;
                if (scan_free && !free_found_reg)
                    free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
            rank_reg[j] <= rank_next[j];
        if (cmd.load)
        begin
            req_cmd_reg <= command;
            req_key_reg <= lookup_key;
            req_val_reg <= write_value;
        end
        if (cmd.scan)
        begin
            if (scan_hit && !match_found_reg)
                match_idx_reg <= scan_idx_reg;
            if (scan_free && !free_found_reg)
                free_idx_reg <= scan_idx_reg;
        end
        if (cmd.commit)
        begin
            hit_reg <= match_found_reg;
            if (match_found_reg && (req_cmd_reg == CMD_GET))
                read_value_reg <= val_mem[match_idx_reg];
            else
                read_value_reg <= '0;
            if (match_found_reg)
            begin
                if (req_cmd_reg == CMD_PUT)
                    val_mem[match_idx_reg] <= req_val_reg;
            end
            else if ((req_cmd_reg == CMD_PUT) && free_found_reg)
            begin
                key_mem[free_idx_reg] <= req_key_reg;
                val_mem[free_idx_reg] <= req_val_reg;
            end
        end
    end

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative 16-entry key/value cache with LRU replacement.
// ----------------------------------------------------------------------------
// Request channel (in_valid/in_ready): command (0 get, 1 put), lookup_key,
// write_value. Result channel (out_valid/out_ready): hit, read_value; one
// result beat per request beat. A get miss and every put return read_value 0.
// Config channel (cfg_valid/cfg_ready): capacity, always ready; write only
// while no request is in flight. Capacity 0 acts as 1, above 16 acts as 16.
// Each request passes through an accept step, a scan over all 16 entries that
// compares one stored key per cycle on a single comparator, and a commit
// step that updates the recency ranks and valid bits and loads the result
// register. in_ready is high only between requests; a new request is taken
// while the previous result still waits. If the receiver stalls, the commit
// cycle holds until the result register is free, so nothing is dropped.
// Reset empties the cache (all entries invalid, count zero) and sets
// capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic signed [KEY_W-1:0] lookup_key,
    input  logic signed [VAL_W-1:0] write_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit,
    output logic signed [VAL_W-1:0] read_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        capacity
);

    lkvc_cmd_t    cmd;
    lkvc_status_t status;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .command     (command),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (capacity),
        .hit         (hit),
        .read_value  (read_value)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key/value cache. A behavioral copy of the
// store (keys, values, valid bits, recency ranks, count) predicts hit and
// read_value for every accepted access. Directed tests cover the key
// extremes, updates, one-bit near misses, eviction order and capacity
// clamping. Random phases then mix gets and puts on a working set sized
// around the capacity, under several capacities, with random idle on both
// sides.
// ----------------------------------------------------------------------------
module tb_top;
    import lkvc_pkg::*;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] value;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    command = CMD_GET;
    logic signed [KEY_W-1:0] lookup_key = '0;
    logic signed [VAL_W-1:0] write_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b1;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        cfg_capacity = CAP_RESET;

    lru_key_value_cache_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .read_value  (read_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (cfg_capacity)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cache shadow
    logic [KEY_W-1:0] shadow_key   [DEPTH];
    logic [VAL_W-1:0] shadow_value [DEPTH];
    bit               shadow_valid [DEPTH];
    int unsigned      shadow_rank  [DEPTH];
    int unsigned      shadow_count = 0;
    logic [CAP_W-1:0] shadow_capacity = CAP_RESET;

    access_result_t   expected_results [$];
    logic [KEY_W-1:0] key_pool [$];

    bit          burst_mode = 1'b0;
    bit          req_raised = 1'b0;
    int unsigned stall_left = 0;
    int unsigned fail_count = 0;
    int unsigned hit_count = 0;
    int unsigned get_count = 0;
    int unsigned put_count = 0;
    int unsigned cap_writes = 0;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
    end

    function automatic int unsigned effective_capacity(input logic [CAP_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > DEPTH)
            return DEPTH;
        return cap;
    endfunction

    function automatic void predict_access(input logic cmd, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val,
                                           output access_result_t res);
        int          found;
        int          oldest;
        int          slot;
        int unsigned r;
        found     = -1;
        res.hit   = 1'b0;
        res.value = '0;
        for (int i = 0; i < DEPTH; i++)
            if (found < 0 && shadow_valid[i] && shadow_key[i] == key)
                found = i;
        if (found >= 0)
        begin
            r = shadow_rank[found];
            for (int i = 0; i < DEPTH; i++)
                if (shadow_valid[i] && shadow_rank[i] < r)
                    shadow_rank[i]++;
            shadow_rank[found] = 0;
            res.hit = 1'b1;
            if (cmd == CMD_PUT)
                shadow_value[found] = val;
            else
                res.value = shadow_value[found];
            return;
        end
        if (cmd != CMD_PUT)
            return;
        // lowered capacity: drop oldest entries until there is room for one
        while (shadow_count >= effective_capacity(shadow_capacity) && shadow_count > 0)
        begin
            oldest = -1;
            for (int i = 0; i < DEPTH; i++)
                if (shadow_valid[i] && (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
                    oldest = i;
            shadow_valid[oldest] = 1'b0;
            shadow_count--;
        end
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && !shadow_valid[i])
                slot = i;
        for (int i = 0; i < DEPTH; i++)
            if (shadow_valid[i])
                shadow_rank[i]++;
        shadow_key[slot]   = key;
        shadow_value[slot] = val;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot]  = 0;
        shadow_count++;
    endfunction

    task automatic send_access(input logic cmd, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val);
        int unsigned    gap;
        access_result_t want;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap != 0 && req_raised)
        begin
            in_valid   <= 1'b0;
            req_raised  = 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        lookup_key  <= key;
        write_value <= val;
        req_raised   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_access(cmd, key, val, want);
        expected_results.insert(expected_results.size(), want);
        if (cmd == CMD_PUT)
            put_count++;
        else
            get_count++;
    endtask

    task automatic drain_results();
        if (req_raised)
        begin
            in_valid   <= 1'b0;
            req_raised  = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_valid    <= 1'b1;
        cfg_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_capacity = cap;
        cap_writes++;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: hit=%0b read_value=%h", hit, read_value);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, hit);
                    fail_count++;
                end
                if (read_value !== want.value)
                begin
                    $error("read_value: expected %h, got %h", want.value, read_value);
                    fail_count++;
                end
                if (want.hit)
                    hit_count++;
            end
            stall_left = burst_mode ? 0 : $urandom_range(0, 7);
            out_ready <= (stall_left == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    task automatic test_reset_miss();
        send_access(CMD_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    endtask

    task automatic test_key_extremes();
        send_access(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_access(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_access(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_access(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_access(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_access(CMD_PUT, 32'h8000_0000, 32'h0000_0001);
        send_access(CMD_GET, 32'h8000_0001, 32'h0000_0000);
        send_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    endtask

    // capacity lowered below the count: first new put evicts down before insert
    task automatic test_lru_order();
        write_capacity(5'd2);
        send_access(CMD_PUT, 32'h0000_0011, 32'h0000_00A1);
        send_access(CMD_PUT, 32'h0000_0022, 32'h0000_00B2);
        send_access(CMD_GET, 32'h0000_0011, 32'h0000_0000);
        send_access(CMD_PUT, 32'h0000_0033, 32'h0000_00C3);
        send_access(CMD_GET, 32'h0000_0022, 32'h0000_0000);
        send_access(CMD_GET, 32'h0000_0011, 32'h0000_0000);
        send_access(CMD_GET, 32'h0000_0033, 32'h0000_0000);
    endtask

    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_access(CMD_PUT, 32'h1234_5678, 32'h5555_AAAA);
        send_access(CMD_PUT, 32'hEDCB_A987, 32'hAAAA_5555);
        send_access(CMD_GET, 32'h1234_5678, 32'h0000_0000);
        send_access(CMD_GET, 32'hEDCB_A987, 32'h0000_0000);
    endtask

    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int unsigned n_items,
                                    input bit burst);
        int unsigned      pick;
        logic             cmd;
        logic [KEY_W-1:0] key;
        write_capacity(cap);
        burst_mode = burst;
        key_pool.delete();
        repeat (effective_capacity(cap) + $urandom_range(0, 4))
            key_pool.insert(key_pool.size(), $urandom());
        repeat (n_items)
        begin
            if (!burst && $urandom_range(0, 99) == 0)
                drain_results();
            cmd  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (pick == 7)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)]
                      ^ (32'h1 << $urandom_range(0, 31));
            else
                key = $urandom();
            send_access(cmd, key, $urandom());
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_miss();
        test_key_extremes();
        test_lru_order();
        test_capacity_zero();

        run_random_phase(5'd16, 200, 1'b0);
        run_random_phase(5'd1,  200, 1'b0);
        run_random_phase(5'd31, 200, 1'b1);
        run_random_phase(5'd0,  200, 1'b0);
        run_random_phase(5'd17, 200, 1'b0);
        run_random_phase(5'd2,  200, 1'b0);
        run_random_phase(5'd8,  200, 1'b1);
        run_random_phase(5'd15, 200, 1'b0);
        run_random_phase(5'($urandom_range(3, 14)), 200, 1'b0);
        run_random_phase(5'd16, 200, 1'b0);

        drain_results();
        repeat (40) @(posedge clk);

        $display("Ran %0d gets and %0d puts (%0d hits) across %0d capacity writes,",
                 get_count, put_count, hit_count, cap_writes);
        $display("including capacity 0, 1, 16 and values above 16, with random stalls.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> lru_key_value_cache_unit.f
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_unit.sv
tb/tb_top.sv
